// ===== src/go_back_n_sender_window_defines.svh =====
// Assertion macros for the go-back-n sender window block.
// Used by the top level; no other dependencies.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`ifndef SYNTH
`define GBNSW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gbnsw assertion failed");
`define GBNSW_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("gbnsw forbidden condition seen");
`else
`define GBNSW_ASSERT(lbl, prop)
`define GBNSW_NEVER(lbl, expr)
`endif
`endif

// ===== src/gbnsw_pkg.sv =====
// Types and constants shared by the go-back-n sender window modules.
// No dependencies.
package gbnsw_pkg;

    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 16;
    localparam int WIN_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 32;
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 56;
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W      = 6;

    localparam logic [1:0] OP_SEND     = 2'd0;
    localparam logic [1:0] OP_ACK      = 2'd1;
    localparam logic [1:0] OP_TIMEOUT  = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] TIMER_NONE  = 2'd0;
    localparam logic [1:0] TIMER_START = 2'd1;
    localparam logic [1:0] TIMER_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_MAX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SEGMENTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQUENCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED         = 2'd3;

    // One result; packed so that seg_valid sits in the lowest bit.
    typedef struct packed {
        logic             queue_overflow;
        logic [1:0]       timer_action;
        logic [LEN_W-1:0] seg_len;
        logic [SEQ_W-1:0] seg_seq;
        logic             seg_valid;
    } result_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ENQ  = 7'b0000010,
        S_WRD  = 7'b0000100,
        S_WCHK = 7'b0001000,
        S_PRD  = 7'b0010000,
        S_PCHK = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

endpackage

// ===== src/gbnsw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbnsw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/go_back_n_sender_window.sv =====
// Go-back-n sender window: top level with the control sequencer.
// Depends on gbnsw_pkg, gbnsw_ram and go_back_n_sender_window_defines.svh.
//
// Usage: requests enter on s_tvalid/s_tready, opcode on s_tuser, data_len and
// ack_number on s_tdata. Each request yields one or more results on
// m_tvalid/m_tready/m_tdata; m_tuser is high when a result carries a segment
// and m_tlast marks the final result of a request. Segment sequence numbers
// and lengths sit in a RAM indexed by queue slot; sent flags are registers.
// Every request is accepted in the idle state and ends in the finish state. A
// send first enqueues its segments, then walks the window, reading each
// segment from the RAM and then checking it, until it reaches the window
// limit or the queue tail. A timeout walks like a send without the enqueue.
// An ack purges covered segments from the front, each a RAM read and then a
// check, until the queue is empty or the front is no longer covered.
// The block takes one request at a time; s_tready is high
// only when idle. A result waits in the output register while the next one
// is prepared; if the receiver stalls, the walk stops until it frees up.
// Reset empties the queue and loads default configuration; no clearing pass
// is needed. Configuration writes go through cfg_we/cfg_index/cfg_data.
`include "go_back_n_sender_window_defines.svh"
module go_back_n_sender_window #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // opcode[1:0]
    input  logic [1:0]                         s_tuser,
    // data_len[15:0], ack_number[47:16]
    input  logic [gbnsw_pkg::TDATA_IN_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // seg_valid[0]
    output logic                               m_tuser,
    // seg_seq[31:0], seg_len[47:32], timer_action[49:48], queue_overflow[50],
    // zero fill
    output logic [gbnsw_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [gbnsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbnsw_pkg::CFG_W-1:0]        cfg_data
);
    import gbnsw_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       segmax_reg, segmax_next;
    logic [WIN_W-1:0]       winseg_reg, winseg_next;
    logic [SEQ_W-1:0]       base_reg, base_next;
    logic [SEQ_W-1:0]       nseq_reg, nseq_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] sent_reg, sent_next;
    logic [LEN_W-1:0]       remain_reg, remain_next;
    logic [SEQ_W-1:0]       limit_reg, limit_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       walk_reg, walk_next;
    logic [NRES_W-1:0]      nres_reg, nres_next;
    logic [1:0]             pend_reg, pend_next;
    logic                   ovf_reg, ovf_next;
    result_t                hold_reg, hold_next;
    logic                   holdv_reg, holdv_next;
    result_t                out_reg, out_next;
    logic                   outv_reg, outv_next;
    logic                   outl_reg, outl_next;

    logic [1:0]             in_opcode;
    logic [LEN_W-1:0]       in_len;
    logic [SEQ_W-1:0]       in_ack;
    logic [LEN_W-1:0]       eff_seg;
    logic [CNT_W:0]         tail_sum;
    logic [IDX_W-1:0]       tail;
    logic [LEN_W-1:0]       piece;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [LEN_W+SEQ_W-1:0] ram_rdata;
    logic [SEQ_W-1:0]       d_seq;
    logic [LEN_W-1:0]       d_len;
    logic [SEQ_W-1:0]       ack_diff;
    logic [SEQ_W-1:0]       lim_diff;
    logic [SEQ_W-1:0]       cover_diff;
    logic                   out_free;
    logic [1:0]             seg_timer;
    logic                   fin_go;

    assign in_opcode = s_tuser;
    assign in_len    = s_tdata[15:0];
    assign in_ack    = s_tdata[47:16];
    assign eff_seg   = (segmax_reg == '0) ? LEN_W'(1) : segmax_reg;

    // Tail slot: head plus count, wrapped once.
    assign tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                ? IDX_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                : IDX_W'(tail_sum);
    assign piece = (remain_reg < eff_seg) ? remain_reg : eff_seg;

    assign ram_raddr = (state_reg == S_PRD || state_reg == S_PCHK) ? head_reg : ptr_reg;
    assign d_seq = ram_rdata[SEQ_W-1:0];
    assign d_len = ram_rdata[LEN_W+SEQ_W-1:SEQ_W];

    assign ack_diff   = in_ack - base_reg;
    assign lim_diff   = d_seq - limit_reg;
    assign cover_diff = base_reg - (d_seq + SEQ_W'(d_len));
    assign out_free   = !outv_reg || m_tready;
    assign seg_timer  = (pend_reg != TIMER_NONE) ? pend_reg
                      : ((d_seq == base_reg) ? TIMER_START : TIMER_NONE);
    assign fin_go     = (state_reg == S_FIN) && out_free;

    gbnsw_ram #(
        .WIDTH (LEN_W + SEQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail),
        .wdata ({piece, nseq_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        segmax_next = segmax_reg;
        winseg_next = winseg_reg;
        base_next   = base_reg;
        nseq_next   = nseq_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        sent_next   = sent_reg;
        remain_next = remain_reg;
        limit_next  = limit_reg;
        ptr_next    = ptr_reg;
        walk_next   = walk_reg;
        nres_next   = nres_reg;
        pend_next   = pend_reg;
        ovf_next    = ovf_reg;
        hold_next   = hold_reg;
        holdv_next  = holdv_reg;
        out_next    = out_reg;
        outv_next   = outv_reg;
        outl_next   = outl_reg;
        ram_we      = 1'b0;

        if (outv_reg && m_tready)
        begin
            outv_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEGMENT_MAX:     segmax_next = cfg_data[LEN_W-1:0];
                CFG_WINDOW_SEGMENTS: winseg_next = cfg_data[WIN_W-1:0];
                CFG_INITIAL_SEQUENCE:
                begin
                    base_next  = cfg_data;
                    nseq_next  = cfg_data;
                    head_next  = '0;
                    count_next = '0;
                    sent_next  = '0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    nres_next  = '0;
                    pend_next  = TIMER_NONE;
                    ovf_next   = 1'b0;
                    holdv_next = 1'b0;
                    ptr_next   = head_reg;
                    walk_next  = '0;
                    limit_next = base_reg + SEQ_W'(winseg_reg) * SEQ_W'(eff_seg);
                    case (in_opcode)
                        OP_SEND:
                        begin
                            remain_next = in_len;
                            state_next  = S_ENQ;
                        end
                        OP_ACK:
                        begin
                            if (ack_diff != '0 && !ack_diff[SEQ_W-1])
                            begin
                                base_next  = in_ack;
                                state_next = S_PRD;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            if (count_reg != '0)
                            begin
                                sent_next  = '0;
                                pend_next  = TIMER_START;
                                state_next = S_WRD;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_ENQ:
            begin
                if (remain_reg == '0)
                begin
                    state_next = S_WRD;
                end
                else if (count_reg == DEPTH_C)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    ram_we          = 1'b1;
                    sent_next[tail] = 1'b0;
                    count_next      = count_reg + CNT_W'(1);
                    nseq_next       = nseq_reg + SEQ_W'(piece);
                    remain_next     = remain_reg - piece;
                end
            end
            S_WRD:
            begin
                state_next = (walk_reg >= count_reg) ? S_FIN : S_WCHK;
            end
            S_WCHK:
            begin
                // The walk ends at the first segment at or past the window limit.
                if (!lim_diff[SEQ_W-1])
                begin
                    state_next = S_FIN;
                end
                else if (sent_reg[ptr_reg])
                begin
                    ptr_next   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
                    walk_next  = walk_reg + CNT_W'(1);
                    state_next = S_WRD;
                end
                else if (nres_reg >= NRES_W'(MAX_RESULTS))
                begin
                    state_next = S_FIN;
                end
                else if (!holdv_reg || out_free)
                begin
                    // The held segment goes out once a newer one proves it is not last.
                    if (holdv_reg)
                    begin
                        out_next  = hold_reg;
                        outv_next = 1'b1;
                        outl_next = 1'b0;
                    end
                    hold_next.queue_overflow = 1'b0;
                    hold_next.timer_action   = seg_timer;
                    hold_next.seg_len        = d_len;
                    hold_next.seg_seq        = d_seq;
                    hold_next.seg_valid      = 1'b1;
                    holdv_next         = 1'b1;
                    sent_next[ptr_reg] = 1'b1;
                    nres_next          = nres_reg + NRES_W'(1);
                    pend_next          = TIMER_NONE;
                    ptr_next   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
                    walk_next  = walk_reg + CNT_W'(1);
                    state_next = S_WRD;
                end
            end
            S_PRD:
            begin
                if (count_reg == '0)
                begin
                    pend_next  = TIMER_STOP;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (cover_diff[SEQ_W-1])
                begin
                    pend_next  = TIMER_START;
                    state_next = S_FIN;
                end
                else
                begin
                    sent_next[head_reg] = 1'b0;
                    head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_PRD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (holdv_reg)
                    begin
                        out_next = hold_reg;
                    end
                    else
                    begin
                        out_next.timer_action = pend_reg;
                        out_next.seg_len      = '0;
                        out_next.seg_seq      = '0;
                        out_next.seg_valid    = 1'b0;
                    end
                    out_next.queue_overflow = ovf_reg;
                    outv_next  = 1'b1;
                    outl_next  = 1'b1;
                    holdv_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            segmax_reg <= LEN_W'(1024);
            winseg_reg <= WIN_W'(8);
            base_reg   <= '0;
            nseq_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            sent_reg   <= '0;
            holdv_reg  <= 1'b0;
            outv_reg   <= 1'b0;
            outl_reg   <= 1'b0;
            nres_reg   <= '0;
            pend_reg   <= TIMER_NONE;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            segmax_reg <= segmax_next;
            winseg_reg <= winseg_next;
            base_reg   <= base_next;
            nseq_reg   <= nseq_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            sent_reg   <= sent_next;
            holdv_reg  <= holdv_next;
            outv_reg   <= outv_next;
            outl_reg   <= outl_next;
            nres_reg   <= nres_next;
            pend_reg   <= pend_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        limit_reg  <= limit_next;
        ptr_reg    <= ptr_next;
        walk_reg   <= walk_next;
        hold_reg   <= hold_next;
        out_reg    <= out_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = outv_reg;
    assign m_tlast  = outl_reg;
    assign m_tuser  = out_reg.seg_valid;
    assign m_tdata  = TDATA_OUT_W'({out_reg.queue_overflow, out_reg.timer_action,
                                    out_reg.seg_len, out_reg.seg_seq});

    `GBNSW_NEVER(a_count_bound, count_reg > DEPTH_C)
    `GBNSW_NEVER(a_hold_idle, holdv_reg && state_reg == S_IDLE)
    `GBNSW_NEVER(a_purge_nonempty, state_reg == S_PCHK && count_reg == '0)
    `GBNSW_ASSERT(a_result_limit, (state_reg == S_WCHK) |-> (nres_reg <= NRES_W'(MAX_RESULTS)))
    `GBNSW_ASSERT(a_fin_to_idle, fin_go |=> (state_reg == S_IDLE && m_tvalid && m_tlast))

endmodule
